>>> sv/rthsl_pkg.sv
// ----------------------------------------------------------------------------
// rthsl_pkg
// Shared widths, constants and structs of the RGB to HSL converter.
// ----------------------------------------------------------------------------
package rthsl_pkg;

   // divider geometry: numerator, divisor and quotient widths
   localparam int NUM_W      = 18;
   localparam int DEN_W      = 9;
   localparam int QUO_W      = 9;
   localparam int DIV_STAGES = QUO_W;

   localparam int CHAN_W = 8;
   localparam int HUE_W  = 9;
   localparam int PCT_W  = 7;

   localparam int CHAN_MAX   = 255;
   localparam int HUE_SCALE  = 60;
   localparam int PCT_SCALE  = 100;
   localparam int LIT_DEN    = 510;

   // lightness divide by 510 as a reciprocal multiply: ceil(2^25 / 510),
   // exact for every numerator up to 100 * 510 + 255
   localparam int LIT_NUM_W  = 16;
   localparam int LIT_PROD_W = 32;
   localparam int LIT_RECIP  = 65794;
   localparam int LIT_SHIFT  = 25;

   typedef struct packed {
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic             valid;
      logic             grey;
      div_req_type      hue;
      div_req_type      sat;
      logic [PCT_W-1:0] lit;
   } front_out_type;

   typedef struct packed {
      logic [HUE_W-1:0] hue;
      logic [PCT_W-1:0] saturation;
      logic [PCT_W-1:0] lightness;
   } hsl_type;

endpackage

>>> sv/rthsl_channels_if.sv
// ----------------------------------------------------------------------------
// rthsl channel interfaces
// Valid/ready channels for RGB pixels in and HSL results out.
// ----------------------------------------------------------------------------
interface rthsl_pixel_if;
   logic                         valid;
   logic                         ready;
   logic [rthsl_pkg::CHAN_W-1:0] red;
   logic [rthsl_pkg::CHAN_W-1:0] green;
   logic [rthsl_pkg::CHAN_W-1:0] blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rthsl_hsl_if;
   logic                        valid;
   logic                        ready;
   logic [rthsl_pkg::HUE_W-1:0] hue;
   logic [rthsl_pkg::PCT_W-1:0] saturation;
   logic [rthsl_pkg::PCT_W-1:0] lightness;

   modport source (output valid, output hue, output saturation, output lightness,
                   input ready);
   modport sink   (input valid, input hue, input saturation, input lightness,
                   output ready);
endinterface

>>> sv/rgb_to_hsl_converter.sv
// ----------------------------------------------------------------------------
// rgb_to_hsl_converter
// RGB pixel to hue (degrees), saturation and lightness (percent), rounded.
// Throughput: one pixel per cycle while the output queue has room; 2 front
// stages, then 9-stage restoring dividers for hue and sat, lightness delayed
// alongside to match.
// Output queue of two entries; input stalls only when it holds two results.
// Reset clears all valid bits and the output queue; no memories to clear.
// ----------------------------------------------------------------------------
module rgb_to_hsl_converter (
   input  logic        clock,
   input  logic        reset,
   rthsl_pixel_if.sink req_if,
   rthsl_hsl_if.source rsp_if
);

   localparam int NS = rthsl_pkg::DIV_STAGES;

   logic                          en;
   rthsl_pkg::front_out_type      front_out;
   logic [rthsl_pkg::QUO_W-1:0]   hue_q, sat_q;
   logic                          valid_ff [NS];
   logic                          grey_ff  [NS];
   logic [rthsl_pkg::PCT_W-1:0]   lit_ff   [NS];
   rthsl_pkg::hsl_type            result;
   logic                          push;

   rthsl_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .req_if    (req_if),
      .front_out (front_out)
   );

   rthsl_divider u_div_hue (
      .clock    (clock),
      .en       (en),
      .div_in   (front_out.hue),
      .quotient (hue_q)
   );

   rthsl_divider u_div_sat (
      .clock    (clock),
      .en       (en),
      .div_in   (front_out.sat),
      .quotient (sat_q)
   );

   // valid, grey and lightness ride alongside the divider stages
   for (genvar s = 0; s < NS; s++) begin : g_side
      logic                        v_prev, g_prev;
      logic [rthsl_pkg::PCT_W-1:0] l_prev;
      if (s == 0) begin : g_first
         assign v_prev = front_out.valid;
         assign g_prev = front_out.grey;
         assign l_prev = front_out.lit;
      end else begin : g_next
         assign v_prev = valid_ff[s-1];
         assign g_prev = grey_ff[s-1];
         assign l_prev = lit_ff[s-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (en) begin
            valid_ff[s] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            grey_ff[s] <= g_prev;
            lit_ff[s]  <= l_prev;
         end
      end
   end

   // grey pixel: hue and saturation forced to zero
   assign result.hue        = grey_ff[NS-1] ? '0 : rthsl_pkg::HUE_W'(hue_q);
   assign result.saturation = grey_ff[NS-1] ? '0 : sat_q[rthsl_pkg::PCT_W-1:0];
   assign result.lightness  = lit_ff[NS-1];
   assign push              = en && valid_ff[NS-1];

   rthsl_out_buffer u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (result),
      .in_ready  (en),
      .rsp_if    (rsp_if)
   );

endmodule

>>> sv/rthsl_front.sv
// ----------------------------------------------------------------------------
// rthsl_front
// Two register stages: max/min and channel select, then the numerators and
// divisors of hue and saturation for the dividers, and the lightness.
// ----------------------------------------------------------------------------
module rthsl_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   rthsl_pixel_if.sink              req_if,
   output rthsl_pkg::front_out_type front_out
);

   typedef enum logic [1:0] {
      SEL_RED,
      SEL_GREEN,
      SEL_BLUE
   } chan_sel_type;

   localparam int W = rthsl_pkg::CHAN_W;
   localparam int WIDE = rthsl_pkg::NUM_W + 1;

   assign req_if.ready = en;

   // stage 1
   logic         v1_ff;
   logic [W-1:0] r1_ff, g1_ff, b1_ff, hi1_ff, lo1_ff;
   chan_sel_type sel1_ff;

   logic [W-1:0] hi_in, lo_in;
   chan_sel_type sel_in;

   always_comb begin
      hi_in = req_if.red;
      lo_in = req_if.red;
      if (req_if.green > hi_in) hi_in = req_if.green;
      if (req_if.blue > hi_in)  hi_in = req_if.blue;
      if (req_if.green < lo_in) lo_in = req_if.green;
      if (req_if.blue < lo_in)  lo_in = req_if.blue;
      if (req_if.red >= req_if.green && req_if.red >= req_if.blue) begin
         sel_in = SEL_RED;
      end else if (req_if.green >= req_if.blue) begin
         sel_in = SEL_GREEN;
      end else begin
         sel_in = SEL_BLUE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r1_ff   <= req_if.red;
         g1_ff   <= req_if.green;
         b1_ff   <= req_if.blue;
         hi1_ff  <= hi_in;
         lo1_ff  <= lo_in;
         sel1_ff <= sel_in;
      end
   end

   // stage 2
   logic [W-1:0]                      d;
   logic [W:0]                        s;
   logic [WIDE-1:0]                   hue_num;
   logic [W:0]                        sat_den;
   logic [rthsl_pkg::LIT_NUM_W-1:0]   lit_num;
   logic [rthsl_pkg::LIT_PROD_W-1:0]  lit_prod;
   rthsl_pkg::front_out_type          out_in;
   rthsl_pkg::front_out_type          out_ff;

   always_comb begin
      d = hi1_ff - lo1_ff;
      s = {1'b0, hi1_ff} + {1'b0, lo1_ff};

      case (sel1_ff)
         SEL_RED: begin
            if (g1_ff >= b1_ff) begin
               hue_num = WIDE'(g1_ff - b1_ff) * WIDE'(rthsl_pkg::HUE_SCALE);
            end else begin
               hue_num = WIDE'(d) * WIDE'(6 * rthsl_pkg::HUE_SCALE)
                       - WIDE'(b1_ff - g1_ff) * WIDE'(rthsl_pkg::HUE_SCALE);
            end
         end
         SEL_GREEN: begin
            hue_num = WIDE'(d) * WIDE'(2 * rthsl_pkg::HUE_SCALE)
                    + WIDE'(b1_ff) * WIDE'(rthsl_pkg::HUE_SCALE)
                    - WIDE'(r1_ff) * WIDE'(rthsl_pkg::HUE_SCALE);
         end
         default: begin
            hue_num = WIDE'(d) * WIDE'(4 * rthsl_pkg::HUE_SCALE)
                    + WIDE'(r1_ff) * WIDE'(rthsl_pkg::HUE_SCALE)
                    - WIDE'(g1_ff) * WIDE'(rthsl_pkg::HUE_SCALE);
         end
      endcase

      // divide by the smaller of S and 510-S
      if (s <= (W+1)'(rthsl_pkg::CHAN_MAX)) begin
         sat_den = s;
      end else begin
         sat_den = (W+1)'(rthsl_pkg::LIT_DEN) - s;
      end

      // lightness: floor((100 S + 255) / 510)
      lit_num  = rthsl_pkg::LIT_NUM_W'(s) * rthsl_pkg::LIT_NUM_W'(rthsl_pkg::PCT_SCALE)
               + rthsl_pkg::LIT_NUM_W'(rthsl_pkg::CHAN_MAX);
      lit_prod = rthsl_pkg::LIT_PROD_W'(lit_num)
               * rthsl_pkg::LIT_PROD_W'(rthsl_pkg::LIT_RECIP);

      // round half up: floor((2n + d) / 2d)
      out_in.valid   = v1_ff;
      out_in.grey    = (d == '0);
      out_in.hue.num = rthsl_pkg::NUM_W'((hue_num << 1) + WIDE'(d));
      out_in.hue.den = {d, 1'b0};
      out_in.sat.num = rthsl_pkg::NUM_W'(d) * rthsl_pkg::NUM_W'(2 * rthsl_pkg::PCT_SCALE)
                     + rthsl_pkg::NUM_W'(sat_den);
      out_in.sat.den = {sat_den[W-1:0], 1'b0};
      out_in.lit     = lit_prod[rthsl_pkg::LIT_SHIFT +: rthsl_pkg::PCT_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else if (en) begin
         out_ff.valid <= out_in.valid;
      end
      if (en) begin
         out_ff.grey <= out_in.grey;
         out_ff.hue  <= out_in.hue;
         out_ff.sat  <= out_in.sat;
         out_ff.lit  <= out_in.lit;
      end
   end

   assign front_out = out_ff;

endmodule

>>> sv/rthsl_divider.sv
// ----------------------------------------------------------------------------
// rthsl_divider
// Pipelined restoring divider, one quotient bit per stage, MSB first.
// Quotient must fit in QUO_W bits.
// ----------------------------------------------------------------------------
module rthsl_divider (
   input  logic                          clock,
   input  logic                          en,
   input  rthsl_pkg::div_req_type        div_in,
   output logic [rthsl_pkg::QUO_W-1:0]   quotient
);

   localparam int NW = rthsl_pkg::NUM_W;
   localparam int DW = rthsl_pkg::DEN_W;
   localparam int QW = rthsl_pkg::QUO_W;
   localparam int NS = rthsl_pkg::DIV_STAGES;

   logic [NW-1:0] rem_ff [NS-1];
   logic [DW-1:0] den_ff [NS-1];
   logic [QW-1:0] quo_ff [NS];

   for (genvar s = 0; s < NS; s++) begin : g_stage
      logic [NW-1:0] rem_prev;
      logic [DW-1:0] den_prev;
      logic [QW-1:0] quo_prev;
      logic [NW-1:0] trial;
      logic          take;

      if (s == 0) begin : g_first
         assign rem_prev = div_in.num;
         assign den_prev = div_in.den;
         assign quo_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[s-1];
         assign den_prev = den_ff[s-1];
         assign quo_prev = quo_ff[s-1];
      end

      assign trial = NW'(den_prev) << (QW - 1 - s);
      assign take  = (rem_prev >= trial);

      always_ff @(posedge clock) begin
         if (en) begin
            quo_ff[s] <= {quo_prev[QW-2:0], take};
         end
      end

      if (s < NS - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[s] <= take ? (rem_prev - trial) : rem_prev;
               den_ff[s] <= den_prev;
            end
         end
      end
   end

   assign quotient = quo_ff[NS-1];

endmodule

>>> sv/rthsl_out_buffer.sv
// ----------------------------------------------------------------------------
// rthsl_out_buffer
// Two-entry output queue; keeps the pipeline moving while a result waits.
// ----------------------------------------------------------------------------
module rthsl_out_buffer (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  rthsl_pkg::hsl_type push_data,
   output logic               in_ready,
   rthsl_hsl_if.source        rsp_if
);

   rthsl_pkg::hsl_type slot_ff [2];
   logic               wr_ptr_ff, rd_ptr_ff;
   logic [1:0]         count_ff;
   logic [1:0]         count_in;
   logic               pop;
   rthsl_pkg::hsl_type head;

   assign in_ready = (count_ff != 2'd2);
   assign pop      = rsp_if.valid && rsp_if.ready;
   assign count_in = count_ff + 2'(push) - 2'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head              = slot_ff[rd_ptr_ff];
   assign rsp_if.valid      = (count_ff != 2'd0);
   assign rsp_if.hue        = head.hue;
   assign rsp_if.saturation = head.saturation;
   assign rsp_if.lightness  = head.lightness;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2)
      else $error("output queue count out of range");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      !(push && count_ff == 2'd2))
      else $error("push into full output queue");

   a_pop_drains: assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> (count_ff == $past(count_ff) - 2'd1))
      else $error("pop without push did not drain one entry");

endmodule

>>> sim/rgb_to_hsl_checker.sv
// ----------------------------------------------------------------------------
// rgb_to_hsl_checker
// Watches both channels of the converter. Each accepted pixel is converted to
// its expected hue, saturation and lightness, and each accepted result is
// compared field by field against the oldest expected one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgb_to_hsl_checker (
   input  logic  clock,
   input  logic  reset,
   rthsl_pixel_if pix_mon,
   rthsl_hsl_if   hsl_mon,
   output int    fail_count,
   output int    pending,
   output int    checked,
   output int    grey_seen,
   output int    hue_360_seen
);

   rthsl_pkg::hsl_type expected_hsl[$];

   // exact quotient rounded half up; all operands are non-negative
   function automatic int unsigned round_div(input int unsigned num, input int unsigned den);
      return (2 * num + den) / (2 * den);
   endfunction

   function automatic rthsl_pkg::hsl_type hsl_of_pixel(
      input logic [rthsl_pkg::CHAN_W-1:0] r,
      input logic [rthsl_pkg::CHAN_W-1:0] g,
      input logic [rthsl_pkg::CHAN_W-1:0] b);
      int unsigned hi, lo, span, total, num, hue_deg, sat_pct;
      rthsl_pkg::hsl_type res;
      hi = r;
      lo = r;
      if (g > hi) hi = g;
      if (b > hi) hi = b;
      if (g < lo) lo = g;
      if (b < lo) lo = b;
      span    = hi - lo;
      total   = hi + lo;
      hue_deg = 0;
      sat_pct = 0;
      if (span != 0) begin
         if (total <= rthsl_pkg::CHAN_MAX) begin
            sat_pct = round_div(rthsl_pkg::PCT_SCALE * span, total);
         end else begin
            sat_pct = round_div(rthsl_pkg::PCT_SCALE * span, rthsl_pkg::LIT_DEN - total);
         end
         // largest channel picks the sector; ties go red, then green
         if (hi == r) begin
            if (g >= b) begin
               num = rthsl_pkg::HUE_SCALE * (g - b);
            end else begin
               num = 6 * rthsl_pkg::HUE_SCALE * span - rthsl_pkg::HUE_SCALE * (b - g);
            end
         end else if (hi == g) begin
            num = 2 * rthsl_pkg::HUE_SCALE * span + rthsl_pkg::HUE_SCALE * b
                - rthsl_pkg::HUE_SCALE * r;
         end else begin
            num = 4 * rthsl_pkg::HUE_SCALE * span + rthsl_pkg::HUE_SCALE * r
                - rthsl_pkg::HUE_SCALE * g;
         end
         hue_deg = round_div(num, span);
      end
      res.hue        = rthsl_pkg::HUE_W'(hue_deg);
      res.saturation = rthsl_pkg::PCT_W'(sat_pct);
      res.lightness  = rthsl_pkg::PCT_W'(round_div(rthsl_pkg::PCT_SCALE * total,
                                                   rthsl_pkg::LIT_DEN));
      return res;
   endfunction

   task automatic report(input string field, input int want, input int got);
      fail_count++;
      $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
   endtask

   always @(posedge clock) begin
      rthsl_pkg::hsl_type want;
      if (reset) begin
         expected_hsl.delete();
         fail_count    = 0;
         pending      <= 0;
         checked      <= 0;
         grey_seen    <= 0;
         hue_360_seen <= 0;
      end else begin
         // result side first so a result cannot match a pixel taken at the same edge
         if (hsl_mon.valid && hsl_mon.ready) begin
            if (expected_hsl.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result hue %0d sat %0d light %0d", $time,
                        hsl_mon.hue, hsl_mon.saturation, hsl_mon.lightness);
            end else begin
               want = expected_hsl.pop_front();
               if (hsl_mon.hue !== want.hue) report("hue", want.hue, hsl_mon.hue);
               if (hsl_mon.saturation !== want.saturation) begin
                  report("saturation", want.saturation, hsl_mon.saturation);
               end
               if (hsl_mon.lightness !== want.lightness) begin
                  report("lightness", want.lightness, hsl_mon.lightness);
               end
               checked <= checked + 1;
            end
         end
         if (pix_mon.valid && pix_mon.ready) begin
            want = hsl_of_pixel(pix_mon.red, pix_mon.green, pix_mon.blue);
            expected_hsl.push_back(want);
            if (pix_mon.red == pix_mon.green && pix_mon.green == pix_mon.blue) begin
               grey_seen <= grey_seen + 1;
            end
            if (want.hue == 360) hue_360_seen <= hue_360_seen + 1;
         end
         pending <= expected_hsl.size();
      end
   end

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives RGB pixels into the converter with random gaps and stalls its result
// channel at random. A directed set of corner pixels comes first, then random
// pixels shaped toward grey, near-grey, tied maxima and hue wrap-around.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

   localparam int RANDOM_PIXELS = 1880;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int DRAIN_CYCLES  = 40;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   cycles = 0;
   int   sent = 0;
   int   taken = 0;
   int   fail_count, pending, checked, grey_seen, hue_360_seen;

   rthsl_pixel_if pix ();
   rthsl_hsl_if   hsl ();

   rgb_to_hsl_converter dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (pix),
      .rsp_if (hsl)
   );

   rgb_to_hsl_checker checker_i (
      .clock        (clock),
      .reset        (reset),
      .pix_mon      (pix),
      .hsl_mon      (hsl),
      .fail_count   (fail_count),
      .pending      (pending),
      .checked      (checked),
      .grey_seen    (grey_seen),
      .hue_360_seen (hue_360_seen)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("rgb_to_hsl_converter: mismatch");
         $finish;
      end
   end

   // one transaction per call; valid stays high across back-to-back pixels
   task automatic send_pixel(input logic [rthsl_pkg::CHAN_W-1:0] r,
                             input logic [rthsl_pkg::CHAN_W-1:0] g,
                             input logic [rthsl_pkg::CHAN_W-1:0] b);
      int gap;
      gap = ((sent / 250) % 4 == 3) ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         pix.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      pix.valid <= 1'b1;
      pix.red   <= r;
      pix.green <= g;
      pix.blue  <= b;
      @(posedge clock);
      while (!pix.ready) @(posedge clock);
      sent++;
   endtask

   task automatic send_random_pixel();
      int kind, r, g, b, hi, lo;
      kind = $urandom_range(0, 9);
      r = $urandom_range(0, 255);
      g = $urandom_range(0, 255);
      b = $urandom_range(0, 255);
      case (kind)
         0: begin
            g = r;
            b = r;
         end
         1: begin
            // near grey: tiny span, large hue sensitivity
            lo = $urandom_range(0, 252);
            r = lo + $urandom_range(0, 3);
            g = lo + $urandom_range(0, 3);
            b = lo + $urandom_range(0, 3);
         end
         2: begin
            // two channels tie for largest
            hi = $urandom_range(1, 255);
            lo = $urandom_range(0, hi - 1);
            case ($urandom_range(0, 2))
               0: begin r = hi; g = hi; b = lo; end
               1: begin r = hi; g = lo; b = hi; end
               default: begin r = lo; g = hi; b = hi; end
            endcase
         end
         3: begin
            // red largest, blue just above green: hue lands at or near 360
            r = $urandom_range(2, 255);
            g = $urandom_range(0, r - 2);
            b = g + 1;
         end
         default: ;
      endcase
      send_pixel(r[rthsl_pkg::CHAN_W-1:0], g[rthsl_pkg::CHAN_W-1:0],
                 b[rthsl_pkg::CHAN_W-1:0]);
   endtask

   // result side: random stall before each transaction, with stretches of none
   initial begin
      int stall;
      hsl.ready <= 1'b0;
      @(negedge reset);
      forever begin
         stall = ((taken / 200) % 4 == 1) ? 0 : $urandom_range(0, 6);
         if (stall > 0) begin
            hsl.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         hsl.ready <= 1'b1;
         @(posedge clock);
         while (!hsl.valid) @(posedge clock);
         taken++;
      end
   end

   initial begin
      pix.valid <= 1'b0;
      pix.red   <= '0;
      pix.green <= '0;
      pix.blue  <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // grey extremes, primaries, secondaries and tied maxima
      send_pixel(8'd0, 8'd0, 8'd0);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd128, 8'd128, 8'd128);
      send_pixel(8'd255, 8'd0, 8'd0);
      send_pixel(8'd0, 8'd255, 8'd0);
      send_pixel(8'd0, 8'd0, 8'd255);
      send_pixel(8'd255, 8'd255, 8'd0);
      send_pixel(8'd255, 8'd0, 8'd255);
      send_pixel(8'd0, 8'd255, 8'd255);
      // hue rounding up to 360
      send_pixel(8'd255, 8'd0, 8'd1);
      send_pixel(8'd200, 8'd10, 8'd11);
      // saturation branch boundary on max+min
      send_pixel(8'd255, 8'd1, 8'd0);
      send_pixel(8'd254, 8'd1, 8'd0);
      send_pixel(8'd1, 8'd0, 8'd0);
      send_pixel(8'd255, 8'd254, 8'd254);
      send_pixel(8'd0, 8'd1, 8'd1);
      send_pixel(8'd1, 8'd0, 8'd1);
      send_pixel(8'd170, 8'd85, 8'd85);
      send_pixel(8'd85, 8'd170, 8'd255);
      send_pixel(8'd127, 8'd128, 8'd128);

      repeat (RANDOM_PIXELS) send_random_pixel();
      pix.valid <= 1'b0;

      // pending is registered, so let the last transaction reach it first
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d pixels sent, %0d results compared", sent, checked);
      $display("%0d grey pixels, %0d results with hue at 360", grey_seen, hue_360_seen);
      if (fail_count == 0) begin
         $display("rgb_to_hsl_converter: match");
      end else begin
         $display("rgb_to_hsl_converter: mismatch");
      end
      $finish;
   end

endmodule

>>> filelist.f
sv/rthsl_pkg.sv
sv/rthsl_channels_if.sv
sv/rthsl_front.sv
sv/rthsl_divider.sv
sv/rthsl_out_buffer.sv
sv/rgb_to_hsl_converter.sv
sim/rgb_to_hsl_checker.sv
sim/testbench.sv
